// File: rtl/lzwh_pkg.sv
`timescale 1ns / 1ps

package lzwh_pkg;

  localparam int LABEL_W  = 13;
  localparam int VALUE_W  = 8;
  localparam int TYPE_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [TYPE_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_REINIT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  localparam logic [31:0] HASH_MASK0 = 32'h0000_00FF;
  localparam logic [31:0] HASH_MASK1 = 32'h0000_FF00;
  localparam logic [31:0] HASH_MASK2 = 32'h00FF_0000;
  localparam logic [31:0] HASH_MASK3 = 32'hFF00_0000;
  localparam logic [VALUE_W-1:0] VALUE_FLIP = 8'hFF;

  typedef struct packed {
    logic [LABEL_W-1:0] child;
    logic [LABEL_W-1:0] parent;
    logic [VALUE_W-1:0] value;
  } slot_t;

  typedef struct packed {
    logic [LABEL_W-1:0]  found_label;
    logic [STATUS_W-1:0] status;
  } res_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_PRELOAD,
    S_IDLE,
    S_HASH_A,
    S_HASH_B,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_RESP
  } state_t;

endpackage

// File: rtl/lzwh_ifs.sv
`timescale 1ns / 1ps

interface lzwh_req_if;
  logic                             valid;
  logic                             ready;
  logic [lzwh_pkg::TYPE_W-1:0]      req_type;
  logic [lzwh_pkg::LABEL_W-1:0]     parent_label;
  logic [lzwh_pkg::VALUE_W-1:0]     child_value;
  logic [lzwh_pkg::LABEL_W-1:0]     child_label;

  modport source (output valid, req_type, parent_label, child_value, child_label,
                  input ready);
  modport sink (input valid, req_type, parent_label, child_value, child_label,
                output ready);
endinterface

interface lzwh_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [lzwh_pkg::LABEL_W-1:0]     found_label;
  logic [lzwh_pkg::STATUS_W-1:0]    status;

  modport source (output valid, found_label, status, input ready);
  modport sink (input valid, found_label, status, output ready);
endinterface

// File: rtl/lzwh_hash.sv
`timescale 1ns / 1ps

module lzwh_hash #(
  parameter int IDX_W = 13
) (
  input  logic                          clk,
  input  logic [lzwh_pkg::LABEL_W-1:0]  parent,
  input  logic [lzwh_pkg::VALUE_W-1:0]  value,
  output logic [IDX_W-1:0]              idx
);

  logic [31:0]                   k;
  logic [31:0]                   p0, p1, p2, p3;
  logic [15:0]                   m01, m23;
  logic [15:0]                   mix;
  logic [lzwh_pkg::VALUE_W-1:0]  vflip;

  // Only the low 16 bits of the 32-bit product can reach the index.
  assign k   = {{(32 - lzwh_pkg::LABEL_W){1'b0}}, parent};
  assign p0  = k ^ lzwh_pkg::HASH_MASK0;
  assign p1  = (k ^ lzwh_pkg::HASH_MASK1) >> 8;
  assign p2  = (k ^ lzwh_pkg::HASH_MASK2) >> 16;
  assign p3  = (k ^ lzwh_pkg::HASH_MASK3) >> 24;
  assign mix = m01 * m23;

  always_ff @(posedge clk) begin
    m01   <= p0[15:0] * p1[15:0];
    m23   <= p2[15:0] * p3[15:0];
    vflip <= value ^ lzwh_pkg::VALUE_FLIP;
    idx   <= mix[IDX_W-1:0] ^ IDX_W'(vflip);
  end

endmodule

// File: rtl/lzwh_slot_ram.sv
`timescale 1ns / 1ps

module lzwh_slot_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  lzwh_pkg::slot_t        wdata,
  input  logic [AW-1:0]          raddr,
  output lzwh_pkg::slot_t        rdata
);

  lzwh_pkg::slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/lzwh_ctrl.sv
`timescale 1ns / 1ps

module lzwh_ctrl #(
  parameter int TABLE_SIZE = 8192,
  parameter int MAX_LABEL  = 4096,
  parameter int FIRST_FREE = 257
) (
  input  logic                          clk,
  input  logic                          rst,
  lzwh_req_if.sink                      req,
  input  logic [lzwh_pkg::LABEL_W-1:0]  root_label,
  output logic                          res_valid,
  input  logic                          res_ready,
  output lzwh_pkg::res_t                res
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int PRE_W = $clog2(FIRST_FREE);

  lzwh_pkg::state_t                 state, state_next;
  logic [lzwh_pkg::TYPE_W-1:0]      op, op_next;
  logic [lzwh_pkg::LABEL_W-1:0]     key_parent, key_parent_next;
  logic [lzwh_pkg::VALUE_W-1:0]     key_value, key_value_next;
  logic [lzwh_pkg::LABEL_W-1:0]     key_label, key_label_next;
  logic                             preload, preload_next;
  logic                             rsp_pending, rsp_pending_next;
  logic [lzwh_pkg::LABEL_W-1:0]     preload_root, preload_root_next;
  logic [IDX_W-1:0]                 clr_idx, clr_idx_next;
  logic [PRE_W-1:0]                 pre_cnt, pre_cnt_next;
  logic [IDX_W-1:0]                 idx, idx_next;
  logic [IDX_W-1:0]                 probes, probes_next;
  lzwh_pkg::res_t                   res_next;

  logic [IDX_W-1:0]                 hash_idx;
  logic                             ram_we;
  logic [IDX_W-1:0]                 ram_waddr;
  lzwh_pkg::slot_t                  ram_wdata;
  logic [IDX_W-1:0]                 ram_raddr;
  lzwh_pkg::slot_t                  slot;
  logic                             slot_empty;
  logic                             slot_match;
  logic                             at_last;
  logic                             label_high;

  lzwh_hash #(.IDX_W(IDX_W)) u_hash (
    .clk    (clk),
    .parent (key_parent),
    .value  (key_value),
    .idx    (hash_idx)
  );

  lzwh_slot_ram #(.DEPTH(TABLE_SIZE), .AW(IDX_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (slot)
  );

  assign slot_empty = (slot.child == '0);
  assign slot_match = (slot.parent == key_parent) && (slot.value == key_value);
  assign at_last    = (probes == '1);
  assign label_high = ({19'd0, req.child_label} > 32'(MAX_LABEL));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lzwh_pkg::S_CLEAR;
      rsp_pending  <= 1'b0;
      preload_root <= '0;
      clr_idx      <= '0;
    end else begin
      state        <= state_next;
      rsp_pending  <= rsp_pending_next;
      preload_root <= preload_root_next;
      clr_idx      <= clr_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    key_parent <= key_parent_next;
    key_value  <= key_value_next;
    key_label  <= key_label_next;
    preload    <= preload_next;
    pre_cnt    <= pre_cnt_next;
    idx        <= idx_next;
    probes     <= probes_next;
    res        <= res_next;
  end

  always_comb begin
    state_next        = state;
    op_next           = op;
    key_parent_next   = key_parent;
    key_value_next    = key_value;
    key_label_next    = key_label;
    preload_next      = preload;
    rsp_pending_next  = rsp_pending;
    preload_root_next = preload_root;
    clr_idx_next      = clr_idx;
    pre_cnt_next      = pre_cnt;
    idx_next          = idx;
    probes_next       = probes;
    res_next          = res;
    ram_we            = 1'b0;
    ram_waddr         = idx;
    ram_wdata         = '{child: key_label, parent: key_parent, value: key_value};
    ram_raddr         = idx + IDX_W'(1);
    req.ready         = 1'b0;
    res_valid         = 1'b0;

    unique case (state)
      lzwh_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
        if (clr_idx == '1) begin
          pre_cnt_next = '0;
          state_next   = lzwh_pkg::S_PRELOAD;
        end else begin
          clr_idx_next = clr_idx + IDX_W'(1);
        end
      end
      lzwh_pkg::S_PRELOAD: begin
        op_next         = lzwh_pkg::REQ_INSERT;
        key_parent_next = preload_root;
        key_value_next  = lzwh_pkg::VALUE_W'(pre_cnt);
        key_label_next  = lzwh_pkg::LABEL_W'(pre_cnt) + lzwh_pkg::LABEL_W'(1);
        preload_next    = 1'b1;
        state_next      = lzwh_pkg::S_HASH_A;
      end
      lzwh_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          op_next         = req.req_type;
          key_parent_next = req.parent_label;
          key_value_next  = req.child_value;
          key_label_next  = req.child_label;
          preload_next    = 1'b0;
          res_next        = '{found_label: '0, status: lzwh_pkg::ST_OK};
          unique case (req.req_type)
            lzwh_pkg::REQ_LOOKUP: begin
              state_next = lzwh_pkg::S_HASH_A;
            end
            lzwh_pkg::REQ_INSERT: begin
              if (label_high) begin
                res_next.status = lzwh_pkg::ST_REJECT;
                state_next      = lzwh_pkg::S_RESP;
              end else begin
                state_next = lzwh_pkg::S_HASH_A;
              end
            end
            lzwh_pkg::REQ_REINIT: begin
              rsp_pending_next  = 1'b1;
              preload_root_next = root_label;
              clr_idx_next      = '0;
              state_next        = lzwh_pkg::S_CLEAR;
            end
            default: begin
              state_next = lzwh_pkg::S_RESP;
            end
          endcase
        end
      end
      lzwh_pkg::S_HASH_A: begin
        state_next = lzwh_pkg::S_HASH_B;
      end
      lzwh_pkg::S_HASH_B: begin
        state_next = lzwh_pkg::S_PROBE_RD;
      end
      lzwh_pkg::S_PROBE_RD: begin
        ram_raddr   = hash_idx;
        idx_next    = hash_idx;
        probes_next = '0;
        state_next  = lzwh_pkg::S_PROBE_CHK;
      end
      lzwh_pkg::S_PROBE_CHK: begin
        // The next slot is read ahead every cycle, so a new slot is checked in each cycle of this state.
        if (op == lzwh_pkg::REQ_INSERT && (slot_empty || at_last)) begin
          ram_we   = slot_empty;
          res_next = '{found_label: '0,
                       status: slot_empty ? lzwh_pkg::ST_OK : lzwh_pkg::ST_FULL};
          if (!preload) begin
            state_next = lzwh_pkg::S_RESP;
          end else if (pre_cnt == PRE_W'(FIRST_FREE - 2)) begin
            state_next = rsp_pending ? lzwh_pkg::S_RESP : lzwh_pkg::S_IDLE;
          end else begin
            pre_cnt_next = pre_cnt + PRE_W'(1);
            state_next   = lzwh_pkg::S_PRELOAD;
          end
        end else if (op != lzwh_pkg::REQ_INSERT && (slot_empty || slot_match || at_last)) begin
          res_next.found_label = (!slot_empty && slot_match) ? slot.child : '0;
          res_next.status      = (!slot_empty && !slot_match) ? lzwh_pkg::ST_FULL
                                                              : lzwh_pkg::ST_OK;
          state_next           = lzwh_pkg::S_RESP;
        end else begin
          idx_next    = idx + IDX_W'(1);
          probes_next = probes + IDX_W'(1);
        end
      end
      lzwh_pkg::S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          rsp_pending_next = 1'b0;
          state_next       = lzwh_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lzwh_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/lzw_dictionary_hash_table.sv
`timescale 1ns / 1ps

// Channel   Direction  Carries
// req       in         req_type, parent_label, child_value, child_label
// rsp       out        found_label, status
// cfg_wr_*  in         root_label, no read-back
//
// A lookup or insert passes S_HASH_A, S_HASH_B and S_PROBE_RD; then the linear
// probe reads one slot per cycle from the single slot memory.
// An insert with an out-of-range label, or an unused request type, goes straight to the response.
// Reset and reinitialize clear every slot of the memory, then preload
// FIRST_FREE-1 root entries; req.ready stays low meanwhile.
// A finished item waits in the output register while the next item is taken.

module lzw_dictionary_hash_table #(
  parameter int TABLE_SIZE = 8192,
  parameter int MAX_LABEL  = 4096,
  parameter int FIRST_FREE = 257
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lzwh_pkg::LABEL_W-1:0]  cfg_wr_data,
  lzwh_req_if.sink                      req,
  lzwh_rsp_if.source                    rsp
);

  logic [lzwh_pkg::LABEL_W-1:0] root_label;
  logic                         res_valid;
  logic                         res_ready;
  lzwh_pkg::res_t               res;
  logic                         out_valid;
  lzwh_pkg::res_t               out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_label <= '0;
    end else if (cfg_wr_en) begin
      root_label <= cfg_wr_data;
    end
  end

  lzwh_ctrl #(
    .TABLE_SIZE (TABLE_SIZE),
    .MAX_LABEL  (MAX_LABEL),
    .FIRST_FREE (FIRST_FREE)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .root_label (root_label),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.found_label = out_res.found_label;
  assign rsp.status      = out_res.status;

`ifndef NO_ASSERTIONS
  a_busy_after_reset: assert property (@(posedge clk) rst |=> !req.ready)
    else $error("request channel ready straight after reset");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("second item taken while one is in progress");

  a_label_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ({19'd0, rsp.found_label} <= 32'(MAX_LABEL)))
    else $error("found label above the maximum");

  a_no_label_on_error: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != lzwh_pkg::ST_OK |-> rsp.found_label == '0)
    else $error("label returned with an error status");
`endif

endmodule
